[hw/rtl/pcbp_pkg.sv]
`timescale 1ns / 1ps

package pcbp_pkg;

  localparam int SYMBOL_COUNT_DEF  = 256;
  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int BYTE_BITS         = 8;
  localparam int POS_W             = 3;   // bit position inside a byte
  localparam int FILL_W            = 4;   // 0..8 bits in a byte

  // control that travels with a looked-up code into the packer
  typedef struct packed {
    logic valid;     // a looked-up code waits in the read register
    logic last;      // end of data: flush the partial byte afterwards
    logic in_range;  // symbol addressed a real table entry
  } load_ctl_t;

endpackage

[hw/rtl/prefix_code_bit_packer.sv]
`timescale 1ns / 1ps
// Channel  Handshake              Word
// item     item_valid/item_stall  operation, symbol, code_bits, code_length, end_of_data
// byte     byte_valid/byte_stall  packed_byte, valid_bits, final_byte
//
// A table write and an encode word's table read are registered; the packer then moves
// the code into the accumulator up to a byte at a time while the next word is read.
// Reset (rst, synchronous) empties accumulator and pipeline; table entries hold
// garbage until written. item_stall rises while a looked-up code waits for the
// packer; byte_stall freezes the output register and the packer behind it.

module prefix_code_bit_packer import pcbp_pkg::*; #(
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_length,
  input  logic        end_of_data,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  packed_byte,
  output logic [3:0]  valid_bits,
  output logic        final_byte
);

  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int LEN_W   = $clog2(MAX_CODE_BITS + 1);
  localparam int ENTRY_W = MAX_CODE_BITS + LEN_W;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // code table: {length, left-aligned code word}
  logic [ENTRY_W-1:0] table_mem [SYMBOL_COUNT];
  logic [ENTRY_W-1:0] rd_data;

  load_ctl_t          ld;
  logic               take;
  logic               accept, in_range;
  logic [ADDR_W-1:0]  addr;
  logic [LEN_W-1:0]   wr_len;

  always_comb begin
    item_stall = ld.valid && !take;
    accept     = item_valid && !item_stall;
    in_range   = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    addr       = symbol[ADDR_W-1:0];
    // lengths past the widest supported code are clamped
    wr_len     = (code_length > 6'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                   : LEN_W'(code_length);
  end

  // write, or registered read for the encode path
  always_ff @(posedge clk) begin
    if (accept && operation == OP_WRITE && in_range) begin
      table_mem[addr] <= {wr_len, code_bits[31 -: MAX_CODE_BITS]};
    end
    if (accept && operation == OP_ENCODE) begin
      rd_data <= table_mem[addr];
    end
  end

  // read stage control; the read register holds while its looked-up code waits for the packer
  always_ff @(posedge clk) begin
    if (rst) begin
      ld.valid <= 1'b0;
    end else begin
      if (accept && operation == OP_ENCODE) begin
        ld.valid    <= 1'b1;
        ld.last     <= end_of_data;
        ld.in_range <= in_range;
      end else if (take) begin
        ld.valid <= 1'b0;
      end
    end
  end

  pcbp_pack #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_pack (
    .clk         (clk),
    .rst         (rst),
    .ld          (ld),
    .ld_code     (rd_data[MAX_CODE_BITS-1:0]),
    .ld_len      (rd_data[ENTRY_W-1 -: LEN_W]),
    .take        (take),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .packed_byte (packed_byte),
    .valid_bits  (valid_bits),
    .final_byte  (final_byte)
  );

endmodule

[hw/rtl/pcbp_pack.sv]
`timescale 1ns / 1ps

module pcbp_pack import pcbp_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  load_ctl_t                ld,
  input  logic [MAX_CODE_BITS-1:0] ld_code,
  input  logic [LEN_W-1:0]         ld_len,
  output logic                     take,
  output logic                     byte_valid,
  input  logic                     byte_stall,
  output logic [BYTE_BITS-1:0]     packed_byte,
  output logic [FILL_W-1:0]        valid_bits,
  output logic                     final_byte
);

  logic                     busy;
  logic [MAX_CODE_BITS-1:0] code;
  logic [LEN_W-1:0]         rem;
  logic                     last;
  logic [BYTE_BITS-1:0]     acc;
  logic [POS_W-1:0]         bitpos;

  logic                 out_free, step;
  logic [FILL_W-1:0]    space, take_n, new_pos;
  logic [BYTE_BITS-1:0] top8, mask, new_acc;
  logic [LEN_W-1:0]     rem_next;
  logic                 done, emit_full, flush, emit, fin;

  always_comb begin
    out_free  = !byte_valid || !byte_stall;
    step      = busy && out_free;
    space     = FILL_W'(BYTE_BITS) - FILL_W'(bitpos);
    take_n    = (rem < LEN_W'(space)) ? FILL_W'(rem) : space;
    top8      = code[MAX_CODE_BITS-1 -: BYTE_BITS];
    mask      = ~(8'hFF >> take_n);
    new_acc   = acc | ((top8 & mask) >> bitpos);
    new_pos   = FILL_W'(bitpos) + take_n;
    rem_next  = rem - LEN_W'(take_n);
    done      = (rem_next == '0);
    emit_full = (new_pos == FILL_W'(BYTE_BITS));
    flush     = done && last && !emit_full && (new_pos != '0);
    emit      = emit_full || flush;
    // a full byte is the item's last unless another full byte or a flush follows
    fin       = flush ||
                (emit_full && (rem_next < LEN_W'(BYTE_BITS)) && !(last && !done));
    take      = ld.valid && (!busy || (step && done));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      acc        <= '0;
      bitpos     <= '0;
      byte_valid <= 1'b0;
    end else begin
      if (step && emit) begin
        byte_valid  <= 1'b1;
        packed_byte <= new_acc;
        valid_bits  <= new_pos;
        final_byte  <= fin;
      end else if (byte_valid && !byte_stall) begin
        byte_valid <= 1'b0;
      end
      if (step) begin
        if (emit) begin
          acc    <= '0;
          bitpos <= '0;
        end else begin
          acc    <= new_acc;
          bitpos <= new_pos[POS_W-1:0];
        end
      end
      // a new code replaces the finished one in the same cycle
      if (take) begin
        busy <= 1'b1;
        code <= ld.in_range ? ld_code : '0;
        rem  <= ld.in_range ? ld_len : '0;
        last <= ld.last;
      end else if (step) begin
        code <= code << take_n;
        rem  <= rem_next;
        if (done) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[test/packed_byte_checker.sv]
`timescale 1ns / 1ps

package pcbp_tb_pkg;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

endpackage

module packed_byte_checker import pcbp_pkg::*; import pcbp_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        operation,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_length,
  input  logic        end_of_data,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  packed_byte,
  input  logic [3:0]  valid_bits,
  input  logic        final_byte,
  output int          fail_count,
  output int          bytes_owed
);

  typedef struct {
    logic [7:0] data;
    logic [3:0] nbits;
    logic       last;
  } out_byte_t;

  logic [31:0] code_word [SYMBOL_COUNT_DEF];
  logic [5:0]  code_len  [SYMBOL_COUNT_DEF];
  logic [7:0]  acc;
  logic [2:0]  pos;
  out_byte_t   pending_bytes[$];
  out_byte_t   want;

  assign bytes_owed = pending_bytes.size();

  // append one symbol's code MSB-first, queue every byte it completes
  task automatic pack_code(input logic [7:0] sym, input logic eod);
    logic [31:0] code;
    int          n;
    int          made;
    out_byte_t   ob;
    code = '0;
    n    = 0;
    made = 0;
    if (sym < SYMBOL_COUNT_DEF) begin
      code = code_word[sym];
      n    = code_len[sym];
    end
    if (n > MAX_CODE_BITS_DEF) n = MAX_CODE_BITS_DEF;
    for (int j = 0; j < n; j++) begin
      acc[7 - pos] = code[31 - j];
      if (pos == 3'd7) begin
        ob = '{acc, 4'd8, 1'b0};
        pending_bytes = {pending_bytes, ob};
        made++;
        acc = '0;
        pos = '0;
      end else begin
        pos++;
      end
    end
    // flush, zero padded; nothing when the accumulator is empty
    if (eod && pos != 3'd0) begin
      ob = '{acc, {1'b0, pos}, 1'b0};
      pending_bytes = {pending_bytes, ob};
      made++;
      acc = '0;
      pos = '0;
    end
    if (made > 0) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc = '0;
      pos = '0;
      pending_bytes.delete();
    end else begin
      if (item_valid && !item_stall) begin
        if (operation == OP_WRITE) begin
          if (symbol < SYMBOL_COUNT_DEF) begin
            code_word[symbol] = code_bits;
            code_len[symbol]  = (code_length > MAX_CODE_BITS_DEF) ?
                                6'(MAX_CODE_BITS_DEF) : code_length;
          end
        end else begin
          pack_code(symbol, end_of_data);
        end
      end
      if (byte_valid && !byte_stall) begin
        if (pending_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, got byte %h bits %0d final %b",
                   $time, packed_byte, valid_bits, final_byte);
        end else begin
          want = pending_bytes.pop_front();
          if (packed_byte !== want.data) begin
            fail_count++;
            $display("%0t: packed_byte expected %h got %h", $time, want.data, packed_byte);
          end
          if (valid_bits !== want.nbits) begin
            fail_count++;
            $display("%0t: valid_bits expected %0d got %0d", $time, want.nbits, valid_bits);
          end
          if (final_byte !== want.last) begin
            fail_count++;
            $display("%0t: final_byte expected %b got %b", $time, want.last, final_byte);
          end
        end
      end
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb import pcbp_tb_pkg::*;;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_WORDS = 350;
  localparam int DRAIN_CYCLES = 20;       // well past the pack time of the longest code
  // worst word: longest idle gap, five bytes each behind the longest stall and the
  // table read, x ~375 words, then a wide margin on top
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        operation;
  logic [7:0]  symbol;
  logic [31:0] code_bits;
  logic [5:0]  code_length;
  logic        end_of_data;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  packed_byte;
  logic [3:0]  valid_bits;
  logic        final_byte;

  int          fail_count;
  int          bytes_owed;
  int          cycles;
  int          stall_left;
  int          stall_draw;
  logic        quiet;            // no idling on either side while set

  // table entries already written; encodes only pick from these
  bit          written [256];
  logic [7:0]  sym_list[$];

  prefix_code_bit_packer DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .operation   (operation),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .end_of_data (end_of_data),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .packed_byte (packed_byte),
    .valid_bits  (valid_bits),
    .final_byte  (final_byte)
  );

  packed_byte_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .operation   (operation),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .end_of_data (end_of_data),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .packed_byte (packed_byte),
    .valid_bits  (valid_bits),
    .final_byte  (final_byte),
    .fail_count  (fail_count),
    .bytes_owed  (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case the block hangs on a handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("prefix_code_bit_packer test failed");
      $finish;
    end
  end

  // Output side: after every accepted word, a random stall is drawn and held.
  // Stall is drawn from the accept, so it lands on any phase of packing.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      byte_stall <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      stall_draw = quiet ? 0 : $urandom_range(0, 10);
      stall_left <= stall_draw;
      byte_stall <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      byte_stall <= (stall_left > 1);
    end
  end

  // Input side: after a random idle gap (none while quiet), present the word and hold it
  // unchanged until accepted. Leaves the caller at the accepting edge.
  task automatic send_word(input op_e op, input logic [7:0] sym, input logic [31:0] bits,
                           input logic [5:0] len, input logic eod);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    operation   <= op;
    symbol      <= sym;
    code_bits   <= bits;
    code_length <= len;
    end_of_data <= eod;
    if (op == OP_WRITE && !written[sym]) begin
      written[sym] = 1'b1;
      sym_list = {sym_list, sym};
    end
    do @(posedge clk); while (item_stall);
  endtask

  initial begin
    logic [5:0] len;
    int         pick;

    rst         = 1'b1;
    quiet       = 1'b0;
    item_valid  = 1'b0;
    operation   = OP_WRITE;
    symbol      = '0;
    code_bits   = '0;
    code_length = '0;
    end_of_data = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // table writes: widest code (end flag must be ignored), one-bit code
    // at the top index, pad bits set below the code, all-zero code, empty
    // code, and two lengths above 32 that clamp
    send_word(OP_WRITE, 8'd0,   32'hFFFF_FFFF, 6'd32, 1'b1);
    send_word(OP_WRITE, 8'd255, 32'h8000_0000, 6'd1,  1'b0);
    send_word(OP_WRITE, 8'd1,   32'hA5FF_FFFF, 6'd8,  1'b0);
    send_word(OP_WRITE, 8'd2,   32'h0000_0000, 6'd7,  1'b0);
    send_word(OP_WRITE, 8'd3,   32'hFFFF_FFFF, 6'd0,  1'b0);
    send_word(OP_WRITE, 8'd4,   32'h5A5A_5A5A, 6'd45, 1'b0);
    send_word(OP_WRITE, 8'd5,   32'hC000_0001, 6'd63, 1'b1);
    send_word(OP_WRITE, 8'd6,   32'hB37F_FFFF, 6'd9,  1'b0);
    // aligned byte with end flag: nothing left to flush
    send_word(OP_ENCODE, 8'd1,   $urandom, 6'($urandom), 1'b1);
    send_word(OP_ENCODE, 8'd255, $urandom, 6'($urandom), 1'b0);
    // 32 bits on an unaligned position: four full bytes, bit left over
    send_word(OP_ENCODE, 8'd0,   $urandom, 6'($urandom), 1'b0);
    send_word(OP_ENCODE, 8'd6,   $urandom, 6'($urandom), 1'b0);
    // empty code with end flag: flush of the partial byte only
    send_word(OP_ENCODE, 8'd3,   $urandom, 6'($urandom), 1'b1);
    // empty code again, accumulator empty: no word at all
    send_word(OP_ENCODE, 8'd3,   $urandom, 6'($urandom), 1'b1);
    send_word(OP_ENCODE, 8'd2,   $urandom, 6'($urandom), 1'b0);
    send_word(OP_ENCODE, 8'd255, $urandom, 6'($urandom), 1'b1);
    send_word(OP_ENCODE, 8'd4,   $urandom, 6'($urandom), 1'b1);
    // seven zero bits then flush: an all-zero partial byte still goes out
    send_word(OP_ENCODE, 8'd2,   $urandom, 6'($urandom), 1'b1);
    send_word(OP_ENCODE, 8'd5,   $urandom, 6'($urandom), 1'b0);
    send_word(OP_ENCODE, 8'd0,   $urandom, 6'($urandom), 1'b0);
    send_word(OP_ENCODE, 8'd255, $urandom, 6'($urandom), 1'b1);

    // --- random ---
    // mostly encodes of written entries with an occasional end of data,
    // table rewrites mixed in; lengths lean short, a few run long or clamp
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 40 == 0) quiet <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 20) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)      len = 6'($urandom_range(1, 12));
        else if (pick < 9) len = 6'($urandom_range(13, 32));
        else               len = 6'($urandom_range(0, 63));
        send_word(OP_WRITE, 8'($urandom), $urandom, len, 1'($urandom));
      end else begin
        send_word(OP_ENCODE, sym_list[$urandom_range(0, sym_list.size() - 1)],
                  $urandom, 6'($urandom), ($urandom_range(0, 7) == 0));
      end
    end
    item_valid <= 1'b0;

    // one edge so the checker has booked the last word, then drain and
    // give the packer time to show any stray word
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("prefix_code_bit_packer test passed");
    end else begin
      $display("prefix_code_bit_packer test failed");
    end
    $finish;
  end

endmodule

[prefix_code_bit_packer.f]
hw/rtl/pcbp_pkg.sv
hw/rtl/pcbp_pack.sv
hw/rtl/prefix_code_bit_packer.sv
test/packed_byte_checker.sv
test/tb.sv
